@@ sv/waypoint_path_follower_top_defines.svh @@
// ----------------------------------------------------------------------------
// waypoint path follower assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_PATH_FOLLOWER_TOP_DEFINES_SVH
`define WAYPOINT_PATH_FOLLOWER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define WPF_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("waypoint path follower check failed");

// next-cycle implication
`define WPF_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("waypoint path follower check failed");

`endif

@@ sv/wpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpf_pkg
// shared types and constants of the waypoint path follower
// ----------------------------------------------------------------------------
package wpf_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_FRAC_DEF = 8;
    localparam int COORD_W = 28;
    localparam int SPEED_W = 24;
    localparam int DT_W = 16;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_STOP  = 2'd3
    } func_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic calc_diff;
        logic calc_sq;
        logic calc_cmp;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic finish_move;
        logic finish_snap;
    } wpf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic snap;
        logic no_step;
        logic sqrt_done;
        logic div_done;
    } wpf_sts_t;
endpackage

@@ sv/wpf_ram.sv @@
// ----------------------------------------------------------------------------
// wpf_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module wpf_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/wpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// wpf_ctrl
// sequencer for one tick: fetch, distance, snap test, root, two divisions
// ----------------------------------------------------------------------------
module wpf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              out_free,
    input  wpf_pkg::wpf_sts_t sts,
    output wpf_pkg::wpf_cmd_t cmd,
    output logic              busy,
    output logic              done
);
    import wpf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_DIFF = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_CMP  = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_DIVS = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_DIFF;
            S_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.calc_sq = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.calc_cmp = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sts.snap || sts.no_step)
                begin
                    state_next = S_DONE;
                end
                else if (sts.sqrt_done)
                begin
                    state_next = S_DIVS;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done = 1'b1;
                    cmd.finish_snap = sts.snap;
                    cmd.finish_move = !sts.snap && !sts.no_step;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

@@ sv/wpf_dp.sv @@
// ----------------------------------------------------------------------------
// wpf_dp
// tick datapath: waypoint tables, squared distance, root and dividers
// ----------------------------------------------------------------------------
module wpf_dp #(
    parameter int MAX_POINTS      = wpf_pkg::MAX_POINTS_DEF,
    parameter int COORD_FRAC_BITS = wpf_pkg::COORD_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load_we,
    input  logic [$clog2(MAX_POINTS)-1:0]   load_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
    input  logic signed [wpf_pkg::COORD_W-1:0] in_x,
    input  logic signed [wpf_pkg::COORD_W-1:0] in_y,
    input  logic [wpf_pkg::DT_W-1:0]        in_dt,
    input  logic [wpf_pkg::SPEED_W-1:0]     speed,
    input  wpf_pkg::wpf_cmd_t               cmd,
    output wpf_pkg::wpf_sts_t               sts,
    output logic signed [wpf_pkg::COORD_W-1:0] res_x,
    output logic signed [wpf_pkg::COORD_W-1:0] res_y
);
    import wpf_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int SQW = 2 * DW;
    localparam int STEPW = SPEED_W + DT_W - (24 - COORD_FRAC_BITS);
    localparam int RW = SQW / 2 + 1;
    localparam int RCW = $clog2(RW + 1);
    localparam int NW = STEPW + DW;
    localparam int QCW = $clog2(NW + 1);
    localparam int SH = 24 - COORD_FRAC_BITS;

    logic [COORD_W-1:0] tx_mem, ty_mem;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [STEPW-1:0] step_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [SQW-1:0] d2_reg, s2_reg;
    logic snap_reg, nostep_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [NW-1:0] nx_reg, ny_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg;
    logic [RW-1:0] rx_reg, ry_reg;
    logic [QCW-1:0] qcnt_reg;
    logic negx_reg, negy_reg;
    logic [SPEED_W+DT_W-1:0] prod;
    logic [SQW-1:0] one2;
    logic [RW+1:0] trial;
    logic [RW:0] rxs, rys;
    logic [NW-1:0] magx, magy;
    logic signed [COORD_W-1:0] qxs, qys;

    wpf_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(in_x),
        .raddr(rd_addr), .rdata(tx_mem));
    wpf_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(in_y),
        .raddr(rd_addr), .rdata(ty_mem));

    assign prod = SPEED_W'(speed) * DT_W'(in_dt);
    assign one2 = SQW'(1) << (2 * COORD_FRAC_BITS);
    // restoring root: two bits a step
    assign trial = {root_reg, 2'b01};
    assign magx = dx_reg[DW-1] ? NW'(step_reg) * NW'(-dx_reg) : NW'(step_reg) * NW'(dx_reg);
    assign magy = dy_reg[DW-1] ? NW'(step_reg) * NW'(-dy_reg) : NW'(step_reg) * NW'(dy_reg);
    assign rxs = {rx_reg, nx_reg[NW-1]};
    assign rys = {ry_reg, ny_reg[NW-1]};
    assign qxs = negx_reg ? -qx_reg : qx_reg;
    assign qys = negy_reg ? -qy_reg : qy_reg;

    // sqrt: d2_reg is consumed two bits a step from the top
    logic [RW+1:0] racc;
    always_comb
    begin
        racc = {rem_reg, d2_reg[SQW-1 -: 2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= '0;
            qcnt_reg <= '0;
            snap_reg <= 1'b0;
            nostep_reg <= 1'b0;
        end
        else
        begin
            if (cmd.calc_cmp)
            begin
                snap_reg <= (d2_reg <= one2) || ((step_reg != '0) && (s2_reg >= d2_reg));
                nostep_reg <= (d2_reg > one2) && (step_reg == '0);
                rcnt_reg <= RCW'(SQW / 2);
            end
            else if (cmd.sqrt_step)
            begin
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            if (cmd.div_start)
            begin
                qcnt_reg <= QCW'(NW);
            end
            else if (cmd.div_step)
            begin
                qcnt_reg <= qcnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cx_reg <= in_x;
            cy_reg <= in_y;
            step_reg <= STEPW'(prod >> SH);
        end
        if (cmd.calc_diff)
        begin
            dx_reg <= DW'($signed(tx_mem)) - DW'(cx_reg);
            dy_reg <= DW'($signed(ty_mem)) - DW'(cy_reg);
        end
        if (cmd.calc_sq)
        begin
            d2_reg <= SQW'(dx_reg) * SQW'(dx_reg) + SQW'(dy_reg) * SQW'(dy_reg);
            s2_reg <= SQW'(step_reg) * SQW'(step_reg);
        end
        if (cmd.sqrt_start)
        begin
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            d2_reg <= d2_reg << 2;
            if (racc >= trial)
            begin
                rem_reg <= RW'(racc - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= RW'(racc);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (cmd.div_start)
        begin
            nx_reg <= magx;
            ny_reg <= magy;
            negx_reg <= dx_reg[DW-1];
            negy_reg <= dy_reg[DW-1];
            rx_reg <= '0;
            ry_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            nx_reg <= nx_reg << 1;
            ny_reg <= ny_reg << 1;
            if (rxs >= (RW+1)'(root_reg))
            begin
                rx_reg <= RW'(rxs - (RW+1)'(root_reg));
                qx_reg <= {qx_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                rx_reg <= RW'(rxs);
                qx_reg <= {qx_reg[COORD_W-2:0], 1'b0};
            end
            if (rys >= (RW+1)'(root_reg))
            begin
                ry_reg <= RW'(rys - (RW+1)'(root_reg));
                qy_reg <= {qy_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                ry_reg <= RW'(rys);
                qy_reg <= {qy_reg[COORD_W-2:0], 1'b0};
            end
        end
    end

    assign sts.snap = snap_reg;
    assign sts.no_step = nostep_reg;
    assign sts.sqrt_done = (rcnt_reg == '0);
    assign sts.div_done = (qcnt_reg == '0);
    assign res_x = snap_reg ? $signed(tx_mem) : (cx_reg + qxs);
    assign res_y = snap_reg ? $signed(ty_mem) : (cy_reg + qys);
endmodule

@@ sv/waypoint_path_follower_top.sv @@
// ----------------------------------------------------------------------------
// waypoint_path_follower_top
// moves a 2d position along a stored waypoint list, one word per item
// ----------------------------------------------------------------------------
// Load, start and stop words, and ticks that find no movement to work on, are
// handled at the edge that accepts them and their result word shows on the
// next cycle. A tick that reads the waypoint table steps through setup (read,
// difference, square, compare), then, when it neither snaps nor has no step,
// the restoring root at two bits a step, a load of the dividers and the two
// bit-serial dividers run side by side, and last writes the result once the
// output is free. One word is worked at a time; the input stalls while a tick
// is in progress and while an unread result word is held.
module waypoint_path_follower_top #(
    parameter int MAX_POINTS      = wpf_pkg::MAX_POINTS_DEF,
    parameter int COORD_FRAC_BITS = wpf_pkg::COORD_FRAC_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wpf_pkg::SPEED_W-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         func,
    input  logic [wpf_pkg::IDX_W-1:0]          point_index,
    input  logic [wpf_pkg::CNT_W-1:0]          point_count,
    input  logic signed [wpf_pkg::COORD_W-1:0] coord_x,
    input  logic signed [wpf_pkg::COORD_W-1:0] coord_y,
    input  logic [wpf_pkg::DT_W-1:0]           delta_t,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [wpf_pkg::COORD_W-1:0] pos_x,
    output logic signed [wpf_pkg::COORD_W-1:0] pos_y,
    output logic                               pos_written,
    output logic                               is_moving,
    output logic                               finished,
    output logic [wpf_pkg::CNT_W-1:0]          target_slot
);
    import wpf_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int LW = $clog2(MAX_POINTS + 1);

    logic [SPEED_W-1:0] speed_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] tgt_reg, tgt_next;
    logic mov_reg, mov_next;
    logic ov_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic pw_reg, fin_reg;
    logic [CNT_W-1:0] ts_reg;
    logic [CNT_W-1:0] cnt_sat;

    wpf_cmd_t cmd;
    wpf_sts_t sts;
    logic busy, done, go, acc, out_free, simple;
    logic signed [COORD_W-1:0] rx, ry;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = busy || !out_free;
    assign acc = in_valid && !in_stall;
    assign go = acc && (func == FUNC_TICK) && mov_reg && (32'(tgt_reg) < 32'(len_reg));
    assign simple = acc && !go;
    assign cnt_sat = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : point_count;

    wpf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .go(go), .out_free(out_free), .sts(sts),
        .cmd(cmd), .busy(busy), .done(done));

    wpf_dp #(.MAX_POINTS(MAX_POINTS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .load_we(acc && (func == FUNC_LOAD) && (32'(point_index) < MAX_POINTS)),
        .load_addr(AW'(point_index)), .rd_addr(AW'(tgt_reg)),
        .in_x(coord_x), .in_y(coord_y), .in_dt(delta_t), .speed(speed_reg),
        .cmd(cmd), .sts(sts), .res_x(rx), .res_y(ry));

    always_comb
    begin
        len_next = len_reg;
        tgt_next = tgt_reg;
        mov_next = mov_reg;
        if (simple)
        begin
            case (func)
                FUNC_START:
                begin
                    len_next = LW'(cnt_sat);
                    tgt_next = LW'(1);
                    mov_next = (cnt_sat >= CNT_W'(2)) && (speed_reg != '0);
                end
                FUNC_TICK, FUNC_STOP: mov_next = 1'b0;
                default: mov_next = mov_reg;
            endcase
        end
        else if (done && cmd.finish_snap)
        begin
            tgt_next = tgt_reg + 1'b1;
            mov_next = (tgt_reg + 1'b1) < len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            len_reg <= '0;
            tgt_reg <= '0;
            mov_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                speed_reg <= cfg_wdata;
            end
            len_reg <= len_next;
            tgt_reg <= tgt_next;
            mov_reg <= mov_next;
            if (simple || done)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (simple)
        begin
            px_reg <= '0;
            py_reg <= '0;
            pw_reg <= 1'b0;
            fin_reg <= (func != FUNC_LOAD) && (func != FUNC_START) && mov_reg;
            ts_reg <= CNT_W'(tgt_next);
        end
        else if (done)
        begin
            pw_reg <= cmd.finish_snap || cmd.finish_move;
            px_reg <= (cmd.finish_snap || cmd.finish_move) ? rx : '0;
            py_reg <= (cmd.finish_snap || cmd.finish_move) ? ry : '0;
            fin_reg <= cmd.finish_snap && !mov_next;
            ts_reg <= CNT_W'(tgt_next);
        end
    end

    assign out_valid = ov_reg;
    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_written = pw_reg;
    assign is_moving = mov_reg;
    assign finished = fin_reg;
    assign target_slot = ts_reg;
endmodule

@@ sv/wpf_checker.sv @@
// ----------------------------------------------------------------------------
// wpf_checker
// port level checks of the waypoint path follower
// ----------------------------------------------------------------------------
`include "waypoint_path_follower_top_defines.svh"

module wpf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pos_written,
    input logic is_moving,
    input logic finished,
    input logic signed [27:0] pos_x
);
    `WPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `WPF_ASSERT_IMP(a_fin_idle, clk, rst_n, out_valid && finished, !is_moving)
    `WPF_ASSERT_IMP(a_zero_pos, clk, rst_n, out_valid && !pos_written, pos_x == '0)
    `WPF_ASSERT_NXT(a_one_word, clk, rst_n, in_valid && !in_stall, in_stall || out_valid)
endmodule

bind waypoint_path_follower_top wpf_checker u_wpf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .pos_written(pos_written),
    .is_moving(is_moving), .finished(finished), .pos_x(pos_x));

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives load, start, tick and stop words into the path follower, predicts
// each result from a local model of the waypoint table and motion state, and
// compares every field of every result word in order
// ----------------------------------------------------------------------------
module tb;
    import wpf_pkg::*;

    localparam int NPTS = 64;
    localparam int WDOG_LIMIT = 20000;
    localparam int NPH = 19;

    typedef struct {
        logic signed [27:0] px;
        logic signed [27:0] py;
        logic               wr;
        logic               mv;
        logic               fin;
        logic [6:0]         tslot;
    } motion_res_t;

    int errors = 0;

    task automatic report(input string what, input longint got, input longint exp_v);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
    endtask

    class motion_board;
        longint      wx[NPTS];
        longint      wy[NPTS];
        int unsigned plen;
        int unsigned tpos;
        bit          moving;
        int unsigned spd;
        motion_res_t pending[$];

        function automatic longint unsigned root_floor(input longint unsigned v);
            longint unsigned r = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void note_word(input func_t f, input int unsigned pi, input int unsigned pc,
                                input longint cx, input longint cy, input longint unsigned dt);
            motion_res_t r;
            longint nx = 0;
            longint ny = 0;
            longint tx;
            longint ty;
            longint dx;
            longint dy;
            longint unsigned d2;
            longint unsigned stp;
            longint dist_root;
            bit snap = 0;
            r.wr = 0;
            r.fin = 0;
            case (f)
                FUNC_LOAD:
                begin
                    wx[pi] = cx;
                    wy[pi] = cy;
                end
                FUNC_START:
                begin
                    plen = pc > NPTS ? NPTS : pc;
                    tpos = 1;
                    moving = plen >= 2 && spd > 0;
                end
                FUNC_TICK:
                    if (moving)
                    begin
                        if (tpos >= plen)
                        begin
                            moving = 0;
                            r.fin = 1;
                        end
                        else
                        begin
                            tx = wx[tpos];
                            ty = wy[tpos];
                            dx = tx - cx;
                            dy = ty - cy;
                            d2 = dx * dx + dy * dy;
                            stp = (longint'(spd) * dt) >> 16;
                            if (d2 <= 65536)
                                snap = 1;
                            else if (stp != 0)
                            begin
                                if (stp * stp >= d2)
                                    snap = 1;
                                else
                                begin
                                    dist_root = root_floor(d2);
                                    nx = cx + (longint'(stp) * dx) / dist_root;
                                    ny = cy + (longint'(stp) * dy) / dist_root;
                                    r.wr = 1;
                                end
                            end
                            if (snap)
                            begin
                                nx = tx;
                                ny = ty;
                                r.wr = 1;
                                tpos++;
                                if (tpos >= plen)
                                begin
                                    moving = 0;
                                    r.fin = 1;
                                end
                            end
                        end
                    end
                default:
                begin
                    r.fin = moving;
                    moving = 0;
                end
            endcase
            r.px = r.wr ? nx[27:0] : '0;
            r.py = r.wr ? ny[27:0] : '0;
            r.mv = moving;
            r.tslot = tpos[6:0];
            pending.push_back(r);
        endfunction

        task check_word(input motion_res_t g);
            motion_res_t e;
            if (pending.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (g.px !== e.px) report("pos_x", g.px, e.px);
            if (g.py !== e.py) report("pos_y", g.py, e.py);
            if (g.wr !== e.wr) report("pos_written", g.wr, e.wr);
            if (g.mv !== e.mv) report("is_moving", g.mv, e.mv);
            if (g.fin !== e.fin) report("finished", g.fin, e.fin);
            if (g.tslot !== e.tslot) report("target_slot", g.tslot, e.tslot);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [23:0] cfg_wdata = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [5:0] point_index = '0;
    logic [6:0] point_count = '0;
    logic signed [27:0] coord_x = '0;
    logic signed [27:0] coord_y = '0;
    logic [15:0] delta_t = '0;
    logic out_valid;
    logic out_stall = 1;
    logic signed [27:0] pos_x;
    logic signed [27:0] pos_y;
    logic pos_written;
    logic is_moving;
    logic finished;
    logic [6:0] target_slot;

    motion_board board = new();
    bit loaded[NPTS];
    bit rx_burst = 0;
    bit rx_hold = 0;
    int quiet_cycles = 0;
    int ticks_moved = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    waypoint_path_follower_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .point_index(point_index), .point_count(point_count),
        .coord_x(coord_x), .coord_y(coord_y), .delta_t(delta_t),
        .out_valid(out_valid), .out_stall(out_stall), .pos_x(pos_x), .pos_y(pos_y),
        .pos_written(pos_written), .is_moving(is_moving), .finished(finished),
        .target_slot(target_slot)
    );

    always @(posedge clk)
    begin
        motion_res_t g;
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            g.px = pos_x;
            g.py = pos_y;
            g.wr = pos_written;
            g.mv = is_moving;
            g.fin = finished;
            g.tslot = target_slot;
            if (pos_written && !finished && is_moving) ticks_moved++;
            board.check_word(g);
        end
    end

    // receiver: random stall per word, plain or burst, and one long hold-off
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                out_stall <= 1;
                repeat (400) @(negedge clk);
                rx_hold = 0;
            end
            if (rx_burst)
                out_stall <= 0;
            else
            begin
                w = $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w == 0)
                    out_stall <= 0;
                else
                begin
                    out_stall <= 1;
                    repeat (w) @(negedge clk);
                    out_stall <= 0;
                end
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            // accepted at this edge when stall low; next loop iteration redrives
        end
    end

    task automatic write_speed(input logic [23:0] v);
        in_valid <= 0;
        @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        board.spd = v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // valid stays high after a word so that the next one may follow at once
    task automatic send(input func_t f, input int unsigned pi, input int unsigned pc,
                        input longint cx, input longint cy, input int unsigned dt,
                        input bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 18);
        if (!no_gap && $urandom_range(0, 3) == 0) w = 0;
        if (w != 0)
        begin
            in_valid <= 0;
            repeat (w) @(negedge clk);
        end
        in_valid <= 1;
        func <= f;
        point_index <= pi[5:0];
        point_count <= pc[6:0];
        coord_x <= cx[27:0];
        coord_y <= cy[27:0];
        delta_t <= dt[15:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_word(f, pi, pc, longint'(signed'(cx[27:0])),
                        longint'(signed'(cy[27:0])), dt);
        if (f == FUNC_LOAD) loaded[pi] = 1;
        @(negedge clk);
    endtask

    function automatic longint rnd_coord(input int span);
        if (span == 0)
            return longint'(signed'(28'($urandom())));
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // loads a path of n points around a center, starts it and ticks it along
    task automatic run_path(input int n, input int span, input int tick_cnt, input bit burst);
        longint px;
        longint py;
        int t;
        px = rnd_coord(span);
        py = rnd_coord(span);
        for (int i = 0; i < n; i++)
            send(FUNC_LOAD, i, 0, rnd_coord(span), rnd_coord(span), 0, burst);
        send(FUNC_START, 0, n, 0, 0, 0, burst);
        for (int k = 0; k < tick_cnt; k++)
        begin
            t = board.tpos;
            if (t < NPTS && loaded[t] && $urandom_range(0, 3) == 0)
            begin
                px = board.wx[t] + $urandom_range(0, 400) - 200;
                py = board.wy[t] + $urandom_range(0, 400) - 200;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                px = rnd_coord(span);
                py = rnd_coord(span);
            end
            if (!board.moving || (board.tpos < board.plen && loaded[board.tpos]))
                send(FUNC_TICK, $urandom_range(0, 63), $urandom_range(0, 127),
                     px, py, $urandom_range(0, 65535), burst);
            if (board.pending.size() != 0 && !burst)
            begin
                // let the result come back before the next tick
                in_valid <= 0;
                while (board.pending.size() != 0) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, every function, special cases
        write_speed(24'h000100);
        send(FUNC_TICK, 0, 0, 0, 0, 100, 0);
        send(FUNC_STOP, 0, 0, 0, 0, 0, 0);
        send(FUNC_LOAD, 0, 0, -134217728, 134217727, 0, 0);
        send(FUNC_LOAD, 63, 0, 134217727, -134217728, 0, 0);
        send(FUNC_LOAD, 1, 0, 1000, 1000, 0, 0);
        send(FUNC_LOAD, 2, 0, 1000, 1000, 0, 0);
        send(FUNC_START, 0, 1, 0, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 65535, 0);
        send(FUNC_START, 0, 3, 0, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 1000, 1000, 0, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 65535, 0);
        send(FUNC_TICK, 0, 0, 1000, 1000, 65535, 0);
        send(FUNC_START, 0, 2, 0, 0, 0, 0);
        send(FUNC_STOP, 0, 0, 0, 0, 0, 0);
        drain();
        write_speed(24'hFFFFFF);
        for (int i = 2; i < 63; i++)
            send(FUNC_LOAD, i, 0, 134217727 - i, -134217728 + i, 0, 1);
        send(FUNC_START, 0, 127, 0, 0, 0, 0);
        send(FUNC_TICK, 0, 0, -134217728, 134217727, 65535, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 65535, 0);
        drain();
        write_speed(24'd0);
        send(FUNC_START, 0, 64, 0, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 5, 5, 65535, 0);
        drain();

        // random paths under several speeds
        for (int ph = 0; ph < NPH; ph++)
        begin
            case (ph % 4)
                0: write_speed($urandom_range(1, 24'hFFFFFF));
                1: write_speed($urandom_range(1, 4096));
                2: write_speed(24'hFFFFFF);
                default: write_speed($urandom_range(0, 3));
            endcase
            for (int p = 0; p < 5; p++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send(func_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 127), rnd_coord(0), rnd_coord(0),
                         $urandom_range(0, 65535), 0);
                else
                    run_path($urandom_range(2, 6), p[0] ? 0 : 50000, $urandom_range(4, 14), 0);
                if ($urandom_range(0, 2) == 0)
                    send(FUNC_STOP, 0, 0, 0, 0, 0, 0);
            end
            if (ph == 6)
            begin
                // hold the output side while words keep coming
                rx_hold = 1;
                rx_burst = 1;
                for (int i = 0; i < 20; i++)
                    send(FUNC_LOAD, $urandom_range(0, 63), 0, rnd_coord(0), rnd_coord(0), 0, 1);
                rx_burst = 0;
            end
            if (ph == 9)
            begin
                rx_burst = 1;
                run_path(4, 0, 10, 1);
                rx_burst = 0;
            end
            // pause until every result is back
            drain();
        end

        drain();
        $display("covered random waypoint paths with loads, starts, ticks and stops");
        $display("under %0d speed settings; %0d partial moves checked", 3 + NPH, ticks_moved);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
